>>> rtl/stpq_pkg.sv
// Shared types, constants and codes for the stable time priority queue.
package stpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 54;
	localparam int TIME_W      = 7;
	localparam int KEY_W       = 2 * TIME_W;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_POP    = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_POPPED   = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   customer_id;
		logic [TIME_W-1:0] arrival_hour;
		logic [TIME_W-1:0] arrival_minute;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   out_id;
		logic [TIME_W-1:0] out_hour;
		logic [TIME_W-1:0] out_minute;
		logic [CNT_W-1:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	// Broadcast from the top level to every cell of the row.
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

>>> rtl/stpq_cell.sv
// One slot of the sorted row: holds an entry, compares it and shifts it.
module stpq_cell import stpq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  entry_t    left_entry,
	input  logic      left_after,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      after
);

	entry_t entry_q;

	// The new entry belongs at or before this slot when the slot is empty
	// or holds a strictly later time; equal times stay ahead of it.
	assign after = !occupied || (entry_q.key > ctl.new_entry.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.ins && after) begin
			entry_q <= left_after ? left_entry : ctl.new_entry;
		end
	end

endmodule

>>> rtl/stable_time_priority_queue.sv
// Top level of the stable time priority queue built from a row of cells.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_ready  req_t: mode, id, hour, minute
//  rsp       out        rsp_valid / rsp_ready  rsp_t: status, id, hour, minute, occupancy
//
// All cells compare their key with the new key at once and shift in the
// same edge, so a request may be accepted in every cycle while responses
// drain. The response register holds one result; a new request is
// accepted whenever that register is empty or is being drained in the same
// cycle. After reset the queue is empty; the stored entries are not cleared,
// only the count is. A stalled response blocks further requests.
module stable_time_priority_queue import stpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] cnt_next;
	rsp_t             rsp_next;

	entry_t           entries [QUEUE_DEPTH];
	logic             afters  [QUEUE_DEPTH];
	logic             occ     [QUEUE_DEPTH];

	// The response register frees up when it is empty or taken this cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);

	// An insert into a full queue and a pop of an empty one leave the row alone.
	always_comb begin
		ctl.ins           = accept && (req.mode == MODE_INSERT) && !full;
		ctl.pop           = accept && (req.mode == MODE_POP) && !empty;
		ctl.new_entry.key = {req.arrival_hour, req.arrival_minute};
		ctl.new_entry.id  = req.customer_id;
	end

	// The row of cells; slot zero always holds the earliest entry.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_entry;
		logic   left_after;
		entry_t right_entry;

		assign occ[i] = (cnt_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_after = 1'b0;
		end else begin : g_inner
			assign left_entry = entries[i-1];
			assign left_after = afters[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_body
			assign right_entry = entries[i+1];
		end

		stpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ[i]),
			.left_entry  (left_entry),
			.left_after  (left_after),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.after       (afters[i])
		);
	end

	// Result of the current request, taken from the head slot on a pop.
	always_comb begin
		cnt_next            = cnt_q;
		rsp_next.status     = STATUS_INSERTED;
		rsp_next.out_id     = '0;
		rsp_next.out_hour   = '0;
		rsp_next.out_minute = '0;
		if (req.mode == MODE_INSERT) begin
			if (full) begin
				rsp_next.status = STATUS_FULL;
			end else begin
				cnt_next = cnt_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				rsp_next.status = STATUS_EMPTY;
			end else begin
				cnt_next            = cnt_q - CNT_W'(1);
				rsp_next.status     = STATUS_POPPED;
				rsp_next.out_id     = entries[0].id;
				rsp_next.out_hour   = entries[0].key[KEY_W-1:TIME_W];
				rsp_next.out_minute = entries[0].key[TIME_W-1:0];
			end
		end
		rsp_next.occupancy = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The count never passes the number of slots in the row.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// A waiting response reports the count that the queue holds now.
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.occupancy == cnt_q))
		else $error("response occupancy differs from queue count");

	// Only a pop result carries entry fields.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != STATUS_POPPED) |->
		(rsp_q.out_id == '0 && rsp_q.out_hour == '0 && rsp_q.out_minute == '0))
		else $error("non-pop response carries entry fields");

	// A pop of a non-empty queue always yields a popped status.
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_POP && !empty) |=> (rsp_q.status == STATUS_POPPED))
		else $error("pop of a non-empty queue gave a wrong status");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the stable time priority queue.
`timescale 1ns / 100ps

module testbench;
	import stpq_pkg::*;

	localparam logic [ID_W-1:0] MAX_CUSTOMER_ID = 54'd9999999999999999;
	localparam logic [ID_W-1:0] ALL_ONES_ID     = {ID_W{1'b1}};
	localparam int              LONG_HOLD       = 80;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Software copy of the queue contents, kept sorted by arrival time.
	entry_t held_entries[QUEUE_DEPTH];
	int     held_count = 0;

	// Responses the queue owes us, in request order.
	rsp_t   pending_responses[$];
	int     fail_count = 0;

	// Idle knobs, percent chance per request or per cycle. Written by the
	// stimulus only.
	int     src_gap_pct    = 0;
	int     sink_stall_pct = 0;

	// Each increment asks the response side for one long hold-off.
	int     hold_requests  = 0;
	int     hold_seen      = 0;
	int     hold_left      = 0;
	int     stall_left     = 0;

	stable_time_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the software queue and returns the response
	// the hardware must produce for it. Inserts go behind every entry with
	// an earlier or equal time, so ties leave in arrival order.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t             res;
		logic [KEY_W-1:0] new_key;
		entry_t           head;
		int               pos;
		res     = '0;
		new_key = {r.arrival_hour, r.arrival_minute};
		if (r.mode == MODE_INSERT) begin
			if (held_count >= QUEUE_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_entries[pos].key <= new_key)
					pos++;
				for (int i = held_count; i > pos; i--)
					held_entries[i] = held_entries[i-1];
				held_entries[pos].key = new_key;
				held_entries[pos].id  = r.customer_id;
				held_count++;
				res.status = STATUS_INSERTED;
			end
		end else if (held_count == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			head = held_entries[0];
			for (int i = 1; i < held_count; i++)
				held_entries[i-1] = held_entries[i];
			held_count--;
			res.status     = STATUS_POPPED;
			res.out_id     = head.id;
			res.out_hour   = head.key[KEY_W-1:TIME_W];
			res.out_minute = head.key[TIME_W-1:0];
		end
		res.occupancy = CNT_W'(held_count);
		return res;
	endfunction

	function automatic req_t make_request(input logic mode, input logic [ID_W-1:0] id,
		input int hour, input int minute);
		req_t r;
		r.mode           = mode;
		r.customer_id    = id;
		r.arrival_hour   = TIME_W'(hour);
		r.arrival_minute = TIME_W'(minute);
		return r;
	endfunction

	// Most keys come from a narrow window so that equal times are common;
	// the rest span the whole seven bits. Pops carry random noise in the
	// fields they ignore.
	function automatic req_t random_request(input logic mode);
		logic [63:0]     raw;
		logic [ID_W-1:0] id;
		int              hour;
		int              minute;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       id = '0;
			1:       id = ALL_ONES_ID;
			2:       id = MAX_CUSTOMER_ID;
			default: id = raw[ID_W-1:0];
		endcase
		if ($urandom_range(0, 3) != 0) begin
			hour   = $urandom_range(8, 9);
			minute = $urandom_range(0, 3);
		end else begin
			hour   = $urandom_range(0, 127);
			minute = $urandom_range(0, 127);
		end
		return make_request(mode, id, hour, minute);
	endfunction

	// Offers one request and holds it until the queue takes it. Valid is
	// left high so the next request can follow without a bubble; a random
	// gap lowers it.
	task automatic send_request(input req_t r);
		int gap;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_responses.push_back(serve_request(r));
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (pending_responses.size() == 0) begin
			$display("%0t: unexpected response, expected none, got status %0d id %0d",
				$time, got.status, got.out_id);
			fail_count++;
		end else begin
			want = pending_responses.pop_front();
			report_field("status", want.status, got.status);
			report_field("out_id", want.out_id, got.out_id);
			report_field("out_hour", want.out_hour, got.out_hour);
			report_field("out_minute", want.out_minute, got.out_minute);
			report_field("occupancy", want.occupancy, got.occupancy);
		end
	endtask

	// Response side: checks every accepted response and decides the ready
	// for the next cycle. A long hold-off wins over the random stalls.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_response(rsp);
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			stall_left = $urandom_range(0, 9);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Ordering by hour then minute, ties in arrival order, field extremes,
	// and a pop of an empty queue on both ends.
	task automatic test_directed_ordering();
		src_gap_pct    = 20;
		sink_stall_pct = 20;
		send_request(make_request(MODE_POP, '0, 0, 0));
		send_request(make_request(MODE_INSERT, '0, 12, 30));
		send_request(make_request(MODE_INSERT, ALL_ONES_ID, 12, 30));
		send_request(make_request(MODE_INSERT, MAX_CUSTOMER_ID, 0, 0));
		send_request(make_request(MODE_INSERT, 54'd5, 127, 127));
		send_request(make_request(MODE_INSERT, 54'd6, 99, 99));
		send_request(make_request(MODE_INSERT, 54'd7, 11, 99));
		send_request(make_request(MODE_INSERT, 54'd8, 12, 0));
		send_request(make_request(MODE_INSERT, 54'd9, 12, 30));
		send_request(make_request(MODE_INSERT, 54'd10, 0, 0));
		send_request(make_request(MODE_INSERT, 54'd11, 0, 127));
		send_request(make_request(MODE_INSERT, 54'd12, 127, 0));
		repeat (12)
			send_request(make_request(MODE_POP, ALL_ONES_ID, 127, 127));
	endtask

	// Drains the queue, fills it, pushes past the top so inserts get dropped,
	// then empties it and pops once more.
	task automatic test_full_and_empty();
		while (held_count != 0)
			send_request(random_request(MODE_POP));
		repeat (QUEUE_DEPTH + 3)
			send_request(random_request(MODE_INSERT));
		repeat (QUEUE_DEPTH + 1)
			send_request(random_request(MODE_POP));
	endtask

	// The response side stops for a long stretch while requests keep
	// coming, so the output register fills and the input is blocked.
	task automatic test_response_stall();
		src_gap_pct = 0;
		hold_requests++;
		repeat (40)
			send_request(random_request($urandom_range(0, 9) < 7 ? MODE_INSERT : MODE_POP));
		src_gap_pct = 20;
	endtask

	// The request side goes quiet until every response is back, then
	// resumes against a completely idle queue.
	task automatic test_drain_pause();
		repeat (10)
			send_request(random_request($urandom_range(0, 1) ? MODE_INSERT : MODE_POP));
		wait_until_drained();
		repeat (10)
			send_request(random_request($urandom_range(0, 1) ? MODE_INSERT : MODE_POP));
	endtask

	// Mixed traffic. The insert share swings between phases so the queue
	// keeps running full and running dry; the idle levels change too,
	// including stretches with no idling at all.
	task automatic test_random_traffic(input int count);
		int insert_pct;
		insert_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				src_gap_pct    = 20 * $urandom_range(0, 2);
				sink_stall_pct = 20 * $urandom_range(0, 2);
			end
			if (n % 48 == 0)
				insert_pct = 20 + 30 * $urandom_range(0, 2);
			send_request(random_request(
				$urandom_range(0, 99) < insert_pct ? MODE_INSERT : MODE_POP));
		end
	endtask

	// Full rate on both sides for the closing stretch.
	task automatic test_back_to_back(input int count);
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		repeat (count)
			send_request(random_request($urandom_range(0, 99) < 55 ? MODE_INSERT : MODE_POP));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_ordering();
		test_full_and_empty();
		test_response_stall();
		test_drain_pause();
		test_random_traffic(1600);
		test_back_to_back(130);

		wait_until_drained();
		// Leave room for any stray response to show up.
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** stable_time_priority_queue: PASSED **");
		else
			$display("** stable_time_priority_queue: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("** stable_time_priority_queue: FAILED **");
		$finish;
	end

endmodule
